@@ design/sll_pkg.sv @@
package sll_pkg;

	localparam int CAPACITY    = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int ADDR_W      = $clog2(CAPACITY);
	localparam int PTR_W       = $clog2(CAPACITY + 1);

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_ERASE  = 3'd1;
	localparam logic [2:0] OP_SORT   = 3'd2;
	localparam logic [2:0] OP_CLEAR  = 3'd3;
	localparam logic [2:0] OP_DUMP   = 3'd4;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]         operation;
		logic [6:0]         position;
		logic signed [31:0] value_in;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [6:0]         count;
		logic signed [31:0] value_out;
		logic               value_valid;
		logic               last;
	} out_item_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_INS_FREE_RD, S_INS_TAKE, S_INS_HEAD, S_INS_LINK1, S_INS_LINK2,
		S_WALK_INIT, S_WALK_RD, S_WALK_ADV, S_ERS_HEAD_RD, S_ERS_HEAD, S_ERS_FREE, S_ERS_N,
		S_ERS_NN_RD, S_ERS_NN, S_CLEAR, S_DMP_INIT, S_DMP_RD, S_DMP_EMIT, S_SRT_INIT,
		S_SRT_START, S_SRT_LOAD, S_SRT_RD, S_SRT_CMP, S_SRT_END, S_RESP
	} state_t;

	typedef enum logic [4:0] {
		CMD_NOP, CMD_LATCH, CMD_EVAL, CMD_RD_FREE, CMD_TAKE_FREE, CMD_INS_HEAD,
		CMD_INS_LINK1, CMD_INS_LINK2, CMD_WALK_INIT, CMD_WALK_RD, CMD_WALK_ADV,
		CMD_RD_HEAD, CMD_ERS_HEAD, CMD_ERS_FREE, CMD_ERS_N, CMD_RD_FNODE, CMD_ERS_NN,
		CMD_CLEAR, CMD_DMP_INIT, CMD_DMP_RD, CMD_DMP_EMIT, CMD_SRT_INIT, CMD_SRT_START,
		CMD_SRT_LOAD, CMD_SRT_RD, CMD_SRT_CMP, CMD_SRT_END, CMD_RESP
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       reject;
		logic       pos_zero;
		logic       cnt_lt2;
		logic       cnt_zero;
		logic       k_zero;
		logic       k_one;
		logic       k_last;
		logic       pass_one;
	} dp_stat_t;

endpackage

@@ design/sll_ctrl.sv @@
module sll_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  sll_pkg::dp_stat_t stat,
	output sll_pkg::cmd_t     cmd,
	output logic              busy,
	output logic              strobe
);
	import sll_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_DECODE;
			end
			S_DECODE: begin
				priority if (stat.reject) state_d = S_RESP;
				else if (stat.op == OP_INSERT) state_d = S_INS_FREE_RD;
				else if (stat.op == OP_ERASE) state_d = stat.pos_zero ? S_ERS_HEAD_RD : S_WALK_INIT;
				else if (stat.op == OP_SORT) state_d = stat.cnt_lt2 ? S_RESP : S_SRT_INIT;
				else if (stat.op == OP_CLEAR) state_d = S_CLEAR;
				else if (stat.op == OP_DUMP) state_d = stat.cnt_zero ? S_RESP : S_DMP_INIT;
				else state_d = S_RESP;
			end
			S_INS_FREE_RD: state_d = S_INS_TAKE;
			S_INS_TAKE:    state_d = stat.pos_zero ? S_INS_HEAD : S_WALK_INIT;
			S_INS_HEAD:    state_d = S_RESP;
			S_INS_LINK1:   state_d = S_INS_LINK2;
			S_INS_LINK2:   state_d = S_RESP;
			S_WALK_INIT:   state_d = S_WALK_RD;
			S_WALK_RD:     state_d = S_WALK_ADV;
			S_WALK_ADV: begin
				if (!stat.k_zero) state_d = S_WALK_RD;
				else if (stat.op == OP_INSERT) state_d = S_INS_LINK1;
				else state_d = S_ERS_N;
			end
			S_ERS_HEAD_RD: state_d = S_ERS_HEAD;
			S_ERS_HEAD:    state_d = S_ERS_FREE;
			S_ERS_FREE:    state_d = S_RESP;
			S_ERS_N:       state_d = S_ERS_NN_RD;
			S_ERS_NN_RD:   state_d = S_ERS_NN;
			S_ERS_NN:      state_d = S_ERS_FREE;
			S_CLEAR:       state_d = S_RESP;
			S_DMP_INIT:    state_d = S_DMP_RD;
			S_DMP_RD:      state_d = S_DMP_EMIT;
			S_DMP_EMIT:    state_d = stat.k_last ? S_IDLE : S_DMP_RD;
			S_SRT_INIT:    state_d = S_SRT_START;
			S_SRT_START:   state_d = S_SRT_LOAD;
			S_SRT_LOAD:    state_d = S_SRT_RD;
			S_SRT_RD:      state_d = S_SRT_CMP;
			S_SRT_CMP:     state_d = stat.k_one ? S_SRT_END : S_SRT_RD;
			S_SRT_END:     state_d = stat.pass_one ? S_RESP : S_SRT_START;
			S_RESP:        state_d = S_IDLE;
			default:       state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd    = CMD_NOP;
		busy   = 1'b1;
		strobe = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) cmd = CMD_LATCH;
			end
			S_DECODE:      cmd = CMD_EVAL;
			S_INS_FREE_RD: cmd = CMD_RD_FREE;
			S_INS_TAKE:    cmd = CMD_TAKE_FREE;
			S_INS_HEAD:    cmd = CMD_INS_HEAD;
			S_INS_LINK1:   cmd = CMD_INS_LINK1;
			S_INS_LINK2:   cmd = CMD_INS_LINK2;
			S_WALK_INIT:   cmd = CMD_WALK_INIT;
			S_WALK_RD:     cmd = CMD_WALK_RD;
			S_WALK_ADV:    cmd = stat.k_zero ? CMD_NOP : CMD_WALK_ADV;
			S_ERS_HEAD_RD: cmd = CMD_RD_HEAD;
			S_ERS_HEAD:    cmd = CMD_ERS_HEAD;
			S_ERS_FREE:    cmd = CMD_ERS_FREE;
			S_ERS_N:       cmd = CMD_ERS_N;
			S_ERS_NN_RD:   cmd = CMD_RD_FNODE;
			S_ERS_NN:      cmd = CMD_ERS_NN;
			S_CLEAR:       cmd = CMD_CLEAR;
			S_DMP_INIT:    cmd = CMD_DMP_INIT;
			S_DMP_RD:      cmd = CMD_DMP_RD;
			S_DMP_EMIT: begin
				cmd    = CMD_DMP_EMIT;
				strobe = 1'b1;
			end
			S_SRT_INIT:    cmd = CMD_SRT_INIT;
			S_SRT_START:   cmd = CMD_SRT_START;
			S_SRT_LOAD:    cmd = CMD_SRT_LOAD;
			S_SRT_RD:      cmd = CMD_SRT_RD;
			S_SRT_CMP:     cmd = CMD_SRT_CMP;
			S_SRT_END:     cmd = CMD_SRT_END;
			S_RESP: begin
				cmd    = CMD_RESP;
				strobe = 1'b1;
			end
			default:       cmd = CMD_NOP;
		endcase
	end

endmodule

@@ design/sll_datapath.sv @@
module sll_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  sll_pkg::cmd_t      cmd,
	input  sll_pkg::in_item_t  item,
	output sll_pkg::dp_stat_t  stat,
	output sll_pkg::out_item_t result
);
	import sll_pkg::*;

	localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(CAPACITY);

	// Node stores. Link entries never written since the last clear read as i+1.
	logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];
	logic [PTR_W-1:0]       lnk_mem [CAPACITY];
	logic [CAPACITY-1:0]    lnk_vld_q;

	logic [PTR_W-1:0]       head_q, free_q, count_q;
	logic [PTR_W-1:0]       cur_q, nxt_q, fnode_q, k_q, pass_q;
	logic [2:0]             op_q;
	logic [6:0]             pos_q;
	logic [VALUE_WIDTH-1:0] val_q, a_q;
	logic [1:0]             st_q;

	logic [VALUE_WIDTH-1:0] vrd_q;
	logic [PTR_W-1:0]       lrd_data_q;
	logic [ADDR_W-1:0]      lrd_addr_q;
	logic                   lrd_vld_q;
	logic [PTR_W-1:0]       lrd;

	logic                   lre, vre, lwe, vwe;
	logic [PTR_W-1:0]       lra, vra, lwa, vwa, lwd;
	logic [VALUE_WIDTH-1:0] vwd;
	logic signed [63:0]     in_ext;
	logic                   a_gt;
	logic [1:0]             st_eval;
	logic [7:0]             pos_w, cnt_w;

	assign lrd    = lrd_vld_q ? lrd_data_q : PTR_W'({1'b0, lrd_addr_q} + 1'b1);
	assign in_ext = 64'(item.value_in);
	assign a_gt   = $signed(a_q) > $signed(vrd_q);
	assign pos_w  = 8'(pos_q);
	assign cnt_w  = 8'(count_q);

	always_comb begin
		st_eval = ST_DONE;
		if (op_q == OP_INSERT) begin
			if (pos_w > cnt_w) st_eval = ST_RANGE;
			else if (cnt_w >= 8'(CAPACITY) || free_q >= NULL_PTR) st_eval = ST_FULL;
		end else if (op_q == OP_ERASE) begin
			if (pos_w >= cnt_w) st_eval = ST_RANGE;
		end
	end

	assign stat.op       = op_q;
	assign stat.reject   = (st_eval != ST_DONE);
	assign stat.pos_zero = (pos_q == 7'd0);
	assign stat.cnt_lt2  = (count_q < PTR_W'(2));
	assign stat.cnt_zero = (count_q == '0);
	assign stat.k_zero   = (k_q == '0);
	assign stat.k_one    = (k_q == PTR_W'(1));
	assign stat.k_last   = (k_q == count_q - PTR_W'(1));
	assign stat.pass_one = (pass_q == PTR_W'(1));

	always_comb begin
		lre = 1'b0; vre = 1'b0; lwe = 1'b0; vwe = 1'b0;
		lra = cur_q; vra = cur_q; lwa = cur_q; vwa = cur_q;
		lwd = lrd; vwd = val_q;
		unique case (cmd)
			CMD_RD_FREE:  begin lre = 1'b1; lra = free_q; end
			CMD_WALK_RD:  begin lre = 1'b1; lra = cur_q; end
			CMD_RD_HEAD:  begin lre = 1'b1; lra = head_q; end
			CMD_RD_FNODE: begin lre = 1'b1; lra = fnode_q; end
			CMD_DMP_RD:   begin lre = 1'b1; vre = 1'b1; lra = cur_q; vra = cur_q; end
			CMD_SRT_START: begin lre = 1'b1; vre = 1'b1; lra = head_q; vra = head_q; end
			CMD_SRT_RD:   begin lre = 1'b1; vre = 1'b1; lra = nxt_q; vra = nxt_q; end
			CMD_TAKE_FREE: begin vwe = 1'b1; vwa = free_q; vwd = val_q; end
			CMD_INS_HEAD: begin lwe = 1'b1; lwa = fnode_q; lwd = head_q; end
			CMD_INS_LINK1: begin lwe = 1'b1; lwa = fnode_q; lwd = lrd; end
			CMD_INS_LINK2: begin lwe = 1'b1; lwa = cur_q; lwd = fnode_q; end
			CMD_ERS_FREE: begin lwe = 1'b1; lwa = fnode_q; lwd = free_q; end
			CMD_ERS_NN:   begin lwe = 1'b1; lwa = cur_q; lwd = lrd; end
			CMD_SRT_CMP:  begin vwe = 1'b1; vwa = cur_q; vwd = a_gt ? vrd_q : a_q; end
			CMD_SRT_END:  begin vwe = 1'b1; vwa = cur_q; vwd = a_q; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (vwe) val_mem[vwa[ADDR_W-1:0]] <= vwd;
		if (vre) vrd_q <= val_mem[vra[ADDR_W-1:0]];
		if (lwe) lnk_mem[lwa[ADDR_W-1:0]] <= lwd;
		if (lre) begin
			lrd_data_q <= lnk_mem[lra[ADDR_W-1:0]];
			lrd_addr_q <= lra[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lnk_vld_q <= '0;
			lrd_vld_q <= 1'b0;
			head_q    <= NULL_PTR;
			free_q    <= '0;
			count_q   <= '0;
		end else begin
			if (lre) lrd_vld_q <= lnk_vld_q[lra[ADDR_W-1:0]];
			if (cmd == CMD_CLEAR) lnk_vld_q <= '0;
			else if (lwe) lnk_vld_q[lwa[ADDR_W-1:0]] <= 1'b1;
			unique case (cmd)
				CMD_TAKE_FREE: free_q <= lrd;
				CMD_INS_HEAD: begin
					head_q  <= fnode_q;
					count_q <= count_q + PTR_W'(1);
				end
				CMD_INS_LINK2: count_q <= count_q + PTR_W'(1);
				CMD_ERS_HEAD: head_q <= lrd;
				CMD_ERS_FREE: begin
					free_q  <= fnode_q;
					count_q <= count_q - PTR_W'(1);
				end
				CMD_CLEAR: begin
					head_q  <= NULL_PTR;
					free_q  <= '0;
					count_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_LATCH: begin
				op_q  <= item.operation;
				pos_q <= item.position;
				val_q <= in_ext[VALUE_WIDTH-1:0];
				st_q  <= ST_DONE;
			end
			CMD_EVAL:      st_q <= st_eval;
			CMD_TAKE_FREE: fnode_q <= free_q;
			CMD_WALK_INIT: begin
				cur_q <= head_q;
				k_q   <= PTR_W'(pos_q) - PTR_W'(1);
			end
			CMD_WALK_ADV: begin
				cur_q <= lrd;
				k_q   <= k_q - PTR_W'(1);
			end
			CMD_ERS_HEAD:  fnode_q <= head_q;
			CMD_ERS_N:     fnode_q <= lrd;
			CMD_DMP_INIT: begin
				cur_q <= head_q;
				k_q   <= '0;
			end
			CMD_DMP_EMIT: begin
				cur_q <= lrd;
				k_q   <= k_q + PTR_W'(1);
			end
			CMD_SRT_INIT:  pass_q <= count_q - PTR_W'(1);
			CMD_SRT_START: begin
				cur_q <= head_q;
				k_q   <= count_q - PTR_W'(1);
			end
			CMD_SRT_LOAD: begin
				a_q   <= vrd_q;
				nxt_q <= lrd;
			end
			CMD_SRT_CMP: begin
				a_q   <= a_gt ? a_q : vrd_q;
				cur_q <= nxt_q;
				nxt_q <= lrd;
				k_q   <= k_q - PTR_W'(1);
			end
			CMD_SRT_END:   pass_q <= pass_q - PTR_W'(1);
			default: ;
		endcase
	end

	always_comb begin
		result.count = 7'(count_q);
		if (cmd == CMD_DMP_EMIT) begin
			result.status      = ST_DONE;
			result.value_out   = 32'(vrd_q);
			result.value_valid = 1'b1;
			result.last        = stat.k_last;
		end else begin
			result.status      = st_q;
			result.value_out   = '0;
			result.value_valid = 1'b0;
			result.last        = 1'b1;
		end
	end

endmodule

@@ design/static_linked_list_engine_unit.sv @@
// Channel   Direction  Handshake             Beat payload
// -------   ---------  --------------------  ---------------------------------------
// item      in         start && !busy        operation, position, value_in
// result    out        done (one cycle)      status, count, value_out, value_valid, last
//
// One operation is in flight at a time. Busy rises the cycle after the accepted beat
// and falls the cycle after its final result beat. Insert and erase at position p
// walk the list from the head to the node before position p; at position 0 they
// need no walk. Dump gives one result beat per element. Sort is a bubble sort over
// the list in count - 1 passes. Every walk step is a registered read of the link
// store followed by a pointer update. Reset is asynchronous and active low; it
// empties the list at once (the link store is tracked by valid bits, so no
// clearing pass is needed). The receiver cannot stall: each result beat is on
// the result port for exactly one cycle with done high.
module static_linked_list_engine_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  sll_pkg::in_item_t  item,
	output logic               done,
	output sll_pkg::out_item_t result
);
	import sll_pkg::*;

	// The controller sequences each operation as a series of datapath commands.
	cmd_t     cmd;
	dp_stat_t stat;

	sll_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.strobe (done)
	);

	// The datapath holds the node stores, the list and free-chain heads and the
	// walk pointers, and forms each result beat.
	sll_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.stat   (stat),
		.result (result)
	);

endmodule

@@ design/sll_checker.sv @@
module sll_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input sll_pkg::out_item_t result
);
	import sll_pkg::*;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result beat while not busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.last) |=> !busy)
		else $error("still busy after final result beat");

	a_mid_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.last) |-> (result.value_valid && result.status == ST_DONE))
		else $error("non-final beat without element value");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_DONE) |-> (result.last && !result.value_valid))
		else $error("error beat not a single final beat");

endmodule

bind static_linked_list_engine_unit sll_checker u_sll_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

@@ verif/tb_static_linked_list_engine_unit.sv @@
module tb_static_linked_list_engine_unit;
	import sll_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// The block walks its list one registered read at a time, so the slowest
	// item is a sort of a full store.
	localparam int NULL_LINK = CAPACITY;
	localparam int SETTLE_CYCLES = 20;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t item;
	logic done;
	out_item_t result;

	static_linked_list_engine_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	// Shadow of the node store. Values live at the block's width and compare as
	// signed numbers when sorting.
	logic signed [31:0] shadow_values [CAPACITY];
	int shadow_links [CAPACITY];
	int shadow_head;
	int shadow_free;
	int shadow_count;

	in_item_t pending_items [$];
	out_item_t expected_results [$];
	int mismatches = 0;
	int beats_sent = 0;
	int results_seen = 0;
	int dumps_sent = 0;
	int full_hits = 0;
	int range_hits = 0;
	bit hold_sender;
	bit item_taken = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAIL static_linked_list_engine_unit");
		$finish;
	end

	// Rebuilds the free chain in index order and empties the list.
	function automatic void shadow_clear();
		for (int i = 0; i < CAPACITY; i++) begin
			shadow_links[i] = i + 1;
		end
		shadow_head = NULL_LINK;
		shadow_free = 0;
		shadow_count = 0;
	endfunction

	function automatic int node_after(int steps);
		int n;
		n = shadow_head;
		for (int i = 0; i < steps && n < CAPACITY; i++) begin
			n = shadow_links[n];
		end
		return n;
	endfunction

	function automatic out_item_t make_result(logic [1:0] st, logic signed [31:0] v,
			logic vv, logic lst);
		out_item_t r;
		r.status = st;
		r.count = shadow_count[6:0];
		r.value_out = v;
		r.value_valid = vv;
		r.last = lst;
		return r;
	endfunction

	// Applies one operation to the shadow store and queues the result beats
	// that the block must produce for it.
	task automatic predict_list_op(in_item_t it);
		int pos;
		int f;
		int prev;
		int n;
		logic [1:0] st;
		logic signed [31:0] vals [CAPACITY];
		logic signed [31:0] t;
		pos = it.position;
		st = ST_DONE;
		case (it.operation)
			OP_INSERT: begin
				if (pos > shadow_count) begin
					st = ST_RANGE;
				end else if (shadow_count >= CAPACITY) begin
					st = ST_FULL;
				end else begin
					f = shadow_free;
					shadow_free = shadow_links[f];
					shadow_values[f] = it.value_in;
					if (pos == 0) begin
						shadow_links[f] = shadow_head;
						shadow_head = f;
					end else begin
						prev = node_after(pos - 1);
						shadow_links[f] = shadow_links[prev];
						shadow_links[prev] = f;
					end
					shadow_count++;
				end
			end
			OP_ERASE: begin
				if (pos >= shadow_count) begin
					st = ST_RANGE;
				end else begin
					if (pos == 0) begin
						n = shadow_head;
						shadow_head = shadow_links[n];
					end else begin
						prev = node_after(pos - 1);
						n = shadow_links[prev];
						shadow_links[prev] = shadow_links[n];
					end
					shadow_links[n] = shadow_free;
					shadow_free = n;
					shadow_count--;
				end
			end
			OP_SORT: begin
				if (shadow_count >= 2) begin
					n = shadow_head;
					for (int i = 0; i < shadow_count; i++) begin
						vals[i] = shadow_values[n];
						n = shadow_links[n];
					end
					for (int i = 0; i + 1 < shadow_count; i++) begin
						for (int j = i + 1; j < shadow_count; j++) begin
							if (vals[i] > vals[j]) begin
								t = vals[i];
								vals[i] = vals[j];
								vals[j] = t;
							end
						end
					end
					n = shadow_head;
					for (int i = 0; i < shadow_count; i++) begin
						shadow_values[n] = vals[i];
						n = shadow_links[n];
					end
				end
			end
			OP_CLEAR: begin
				shadow_clear();
			end
			OP_DUMP: begin
				if (shadow_count > 0) begin
					n = shadow_head;
					for (int k = 0; k < shadow_count; k++) begin
						expected_results.push_back(make_result(ST_DONE, shadow_values[n], 1'b1,
							k == shadow_count - 1));
						n = shadow_links[n];
					end
					return;
				end
			end
			default: begin
			end
		endcase
		if (st == ST_RANGE) range_hits++;
		if (st == ST_FULL) full_hits++;
		expected_results.push_back(make_result(st, '0, 1'b0, 1'b1));
	endtask

	// Keeps a count of the list as the stimulus is built, so that positions
	// can be aimed at the edges of the list that will exist at that point.
	int plan_count;

	function automatic in_item_t build_item(logic [2:0] op, int pos, logic [31:0] v);
		in_item_t it;
		it.operation = op;
		it.position = pos[6:0];
		it.value_in = v;
		return it;
	endfunction

	task automatic plan(logic [2:0] op, int pos, logic [31:0] v);
		pending_items.push_back(build_item(op, pos, v));
		case (op)
			OP_INSERT: if (pos <= plan_count && plan_count < CAPACITY) plan_count++;
			OP_ERASE: if (pos < plan_count) plan_count--;
			OP_CLEAR: plan_count = 0;
			default: begin
			end
		endcase
	endtask

	function automatic logic [31:0] random_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'(int'($urandom_range(0, 6)) - 3);
			default: return $urandom();
		endcase
	endfunction

	// A random operation, weighted toward list edits so the list grows deep.
	task automatic plan_random();
		int pos;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
				: $urandom_range(0, plan_count);
			plan(OP_INSERT, pos, random_value());
		end else if (pick < 80) begin
			pos = ($urandom_range(0, 9) == 0 || plan_count == 0) ? $urandom_range(0, 127)
				: $urandom_range(0, plan_count - 1);
			plan(OP_ERASE, pos, random_value());
		end else if (pick < 86) begin
			plan(OP_SORT, $urandom_range(0, 127), random_value());
		end else if (pick < 95) begin
			plan(OP_DUMP, $urandom_range(0, 127), random_value());
		end else if (pick < 97) begin
			plan(OP_CLEAR, $urandom_range(0, 127), random_value());
		end else begin
			plan(3'($urandom_range(5, 7)), $urandom_range(0, 127), random_value());
		end
	endtask

	// Driver: one beat per item, with a random gap before each and an
	// optional hold that keeps the sender idle after the block has drained.
	int gap_left;
	bit gap_drawn;

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			gap_drawn <= 1'b0;
			gap_left <= 0;
		end else if (start && item_taken) begin
			// The beat was taken at the last rising edge.
			beats_sent <= beats_sent + 1;
			start <= 1'b0;
			gap_drawn <= 1'b0;
		end else if (!start) begin
			if (!gap_drawn) begin
				gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
				gap_drawn <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
			end else if (pending_items.size() > 0 && !hold_sender) begin
				item <= pending_items.pop_front();
				start <= 1'b1;
			end
		end
	end

	// Monitor: every done beat is checked against the oldest expectation, and
	// every accepted beat is applied to the shadow store at its accepting edge.
	always @(posedge clk) begin
		item_taken <= arst_n && start && !busy;
		if (arst_n && done) begin
			results_seen <= results_seen + 1;
			if (expected_results.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) begin
					$display("unexpected result beat: %p", result);
				end
			end else begin
				out_item_t exp_r;
				exp_r = expected_results.pop_front();
				if (result !== exp_r) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) begin
						$display("result mismatch: expected %p, got %p", exp_r, result);
					end
				end
				if (exp_r.value_valid) dumps_sent <= dumps_sent + 1;
			end
		end
		if (arst_n && start && !busy) begin
			predict_list_op(item);
		end
	end

	task automatic wait_drained();
		while (pending_items.size() > 0 || start || expected_results.size() > 0 || busy) begin
			@(posedge clk);
		end
	endtask

	initial begin
		hold_sender = 1'b0;
		plan_count = 0;
		shadow_clear();
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: empty-list corner cases, edges of each field, the
		// tail and only-element erases, and every unused opcode.
		plan(OP_DUMP, 0, 0);
		plan(OP_ERASE, 0, 0);
		plan(OP_SORT, 0, 0);
		plan(OP_INSERT, 1, 32'h1234_5678);
		plan(OP_INSERT, 0, 32'h8000_0000);
		plan(OP_SORT, 0, 0);
		plan(OP_ERASE, 0, 0);
		plan(OP_INSERT, 0, 32'h7FFF_FFFF);
		plan(OP_INSERT, 1, 32'hFFFF_FFFF);
		plan(OP_INSERT, 1, 32'h8000_0000);
		plan(OP_INSERT, 3, 32'h0000_0000);
		plan(OP_DUMP, 127, 32'hFFFF_FFFF);
		plan(OP_SORT, 0, 0);
		plan(OP_DUMP, 0, 0);
		plan(OP_ERASE, 3, 0);
		plan(OP_ERASE, 2, 0);
		plan(OP_ERASE, 127, 0);
		plan(OP_INSERT, 64, 32'h5555_5555);
		plan(3'd5, 0, 0);
		plan(3'd6, 0, 0);
		plan(3'd7, 127, 32'hFFFF_FFFF);
		plan(OP_CLEAR, 0, 0);
		plan(OP_DUMP, 0, 0);

		// The sender holds back until the block has drained everything.
		wait_drained();
		hold_sender = 1'b1;
		repeat ($urandom_range(2, 6)) @(posedge clk);
		hold_sender = 1'b0;

		// Fill the store to the brim, hit the full case, then sort and dump.
		for (int i = 0; i < CAPACITY; i++) begin
			plan(OP_INSERT, (i % 3 == 0) ? 0 : $urandom_range(0, plan_count), random_value());
		end
		plan(OP_INSERT, 0, 32'h0BAD_0BAD);
		plan(OP_INSERT, 64, 32'h0BAD_0BAD);
		plan(OP_INSERT, 65, 32'h0BAD_0BAD);
		plan(OP_SORT, 0, 0);
		plan(OP_DUMP, 0, 0);
		plan(OP_ERASE, 63, 0);
		plan(OP_ERASE, 0, 0);
		plan(OP_CLEAR, 0, 0);

		for (int i = 0; i < 300; i++) begin
			plan_random();
			// Keep sorts cheap most of the time by trimming big lists.
			if (plan_count > 40 && $urandom_range(0, 3) == 0) plan(OP_CLEAR, 0, 0);
		end
		plan(OP_DUMP, 0, 0);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d operation beats and checked %0d result beats (%0d list elements).",
			beats_sent, results_seen, dumps_sent);
		$display("Out-of-range cases: %0d, full-store cases: %0d.", range_hits, full_hits);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("PASS static_linked_list_engine_unit");
		end else begin
			$display("FAIL static_linked_list_engine_unit");
		end
		$finish;
	end

endmodule
